// ===== sv/dspc_pkg.sv =====
// ----------------------------------------------------------------------------
// Dual setpoint panel package
// Shared types, message codes and seven-segment decoding for the panel.
// ----------------------------------------------------------------------------
package dspc_pkg;

    // Largest value either channel can show
    localparam logic [6:0] VALUE_CEIL = 7'd99;

    // Bus message codes
    localparam logic [7:0] MSG_KIND_VALUE = 8'd1;
    localparam logic [7:0] MSG_CHAN_ONE   = 8'd1;
    localparam logic [7:0] MSG_CHAN_TWO   = 8'd2;

    // Request kinds carried in tuser
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Timing settings seen by each channel
    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] lock_hold_ms;
        logic [15:0] change_blink_len;
        logic [15:0] change_blink_half;
        logic [15:0] lock_blink_half;
        logic [6:0]  eff_max;
    } t_chan_cfg;

    // Per-channel view after an update
    typedef struct packed {
        logic [6:0] value;
        logic       lit;
        logic       locked;
        logic       pushed;
    } t_chan_view;

    // Segments a..g at bit6..bit0 for one decimal digit
    function automatic logic [6:0] f_seg(input logic [3:0] digit);
        logic [6:0] seg;
        unique case (digit)
            4'd0:    seg = 7'h7E;
            4'd1:    seg = 7'h30;
            4'd2:    seg = 7'h6D;
            4'd3:    seg = 7'h79;
            4'd4:    seg = 7'h33;
            4'd5:    seg = 7'h5B;
            4'd6:    seg = 7'h5F;
            4'd7:    seg = 7'h70;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h7B;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

    // Tens digit of a value no greater than 99
    function automatic logic [3:0] f_tens(input logic [6:0] v);
        logic [3:0] t;
        priority if (v >= 7'd90) t = 4'd9;
        else if (v >= 7'd80)     t = 4'd8;
        else if (v >= 7'd70)     t = 4'd7;
        else if (v >= 7'd60)     t = 4'd6;
        else if (v >= 7'd50)     t = 4'd5;
        else if (v >= 7'd40)     t = 4'd4;
        else if (v >= 7'd30)     t = 4'd3;
        else if (v >= 7'd20)     t = 4'd2;
        else if (v >= 7'd10)     t = 4'd1;
        else                     t = 4'd0;
        return t;
    endfunction

endpackage

// ===== sv/dspc_seg.sv =====
// ----------------------------------------------------------------------------
// Dual setpoint panel digit decoder
// Splits a channel value into tens and units and drives their segments,
// blanked while the channel is dark.
// ----------------------------------------------------------------------------
module dspc_seg (
    input  logic [6:0] i_value,
    input  logic       i_lit,
    output logic [6:0] o_seg_tens,
    output logic [6:0] o_seg_units
);
    import dspc_pkg::*;

    logic [6:0] clamped;
    logic [3:0] tens;
    logic [6:0] tens_x10;
    logic [3:0] units;

    // Clamp, then split into decimal digits
    assign clamped  = (i_value > VALUE_CEIL) ? VALUE_CEIL : i_value;
    assign tens     = f_tens(clamped);
    assign tens_x10 = 7'(tens) * 7'd10;
    assign units    = 4'(clamped - tens_x10);

    // Blank both digits in the dark phase
    assign o_seg_tens  = i_lit ? f_seg(tens)  : 7'd0;
    assign o_seg_units = i_lit ? f_seg(units) : 7'd0;

endmodule

// ===== sv/dspc_chan.sv =====
// ----------------------------------------------------------------------------
// Dual setpoint panel channel
// Holds one channel's value, debounce, lock-hold and blink state and
// updates it once per request.
// ----------------------------------------------------------------------------
module dspc_chan #(
    parameter int TIME_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_tick,
    input  logic                  i_up,
    input  logic                  i_dn,
    input  logic                  i_wr,
    input  logic [7:0]            i_wr_value,
    input  logic [TIME_BITS-1:0]  i_now,
    input  dspc_pkg::t_chan_cfg   i_cfg,
    output dspc_pkg::t_chan_view  o_view
);
    import dspc_pkg::*;

    logic [6:0]           r_value,  n_value;
    logic [TIME_BITS-1:0] r_act_t,  n_act_t;
    logic [TIME_BITS-1:0] r_chg_t,  n_chg_t;
    logic [TIME_BITS-1:0] r_tog_t,  n_tog_t;
    logic [TIME_BITS-1:0] r_hold_t, n_hold_t;
    logic                 r_hold,   n_hold;
    logic                 r_lock,   n_lock;
    logic                 r_blink,  n_blink;
    logic                 r_lit,    n_lit;
    logic                 pushed;
    logic [7:0]           stepped;

    // Elapsed ticks, wrapping at the time width
    function automatic logic [TIME_BITS-1:0] f_since(
        input logic [TIME_BITS-1:0] now,
        input logic [TIME_BITS-1:0] t
    );
        return TIME_BITS'(now - t);
    endfunction

    // Work out the next channel state for this request
    always_comb begin
        n_value  = r_value;
        n_act_t  = r_act_t;
        n_chg_t  = r_chg_t;
        n_tog_t  = r_tog_t;
        n_hold_t = r_hold_t;
        n_hold   = r_hold;
        n_lock   = r_lock;
        n_blink  = r_blink;
        n_lit    = r_lit;
        pushed   = 1'b0;
        stepped  = 8'd0;

        if (i_tick) begin
            // Buttons, once the debounce window has passed
            if (f_since(i_now, r_act_t) > TIME_BITS'(i_cfg.debounce_ms)) begin
                if (i_up && i_dn) begin
                    if (!r_hold) begin
                        n_hold   = 1'b1;
                        n_hold_t = i_now;
                    end else if (f_since(i_now, r_hold_t)
                                 >= TIME_BITS'(i_cfg.lock_hold_ms)) begin
                        n_lock  = !r_lock;
                        if (r_lock) begin
                            n_lit = 1'b1;
                        end
                        n_hold  = 1'b0;
                        n_act_t = i_now;
                    end
                end else begin
                    n_hold = 1'b0;
                    if (!r_lock && (i_up || i_dn)) begin
                        if (i_up) begin
                            stepped = 8'(r_value) + 8'd1;
                        end else begin
                            stepped = (r_value != 7'd0) ? 8'(r_value) - 8'd1 : 8'd0;
                        end
                        n_value = (stepped > 8'(i_cfg.eff_max)) ? i_cfg.eff_max
                                                                : stepped[6:0];
                        n_act_t = i_now;
                        n_chg_t = i_now;
                        n_blink = 1'b1;
                        pushed  = 1'b1;
                    end
                end
            end

            // Change blink after a button step or bus write, else the lock blink
            if (n_blink) begin
                if (f_since(i_now, n_chg_t) >= TIME_BITS'(i_cfg.change_blink_len)) begin
                    n_blink = 1'b0;
                    n_lit   = 1'b1;
                end else if (f_since(i_now, n_tog_t)
                             >= TIME_BITS'(i_cfg.change_blink_half)) begin
                    n_lit   = !n_lit;
                    n_tog_t = i_now;
                end
            end else if (n_lock && (f_since(i_now, n_tog_t)
                                    >= TIME_BITS'(i_cfg.lock_blink_half))) begin
                n_lit   = !n_lit;
                n_tog_t = i_now;
            end
        end else if (i_wr && !r_lock) begin
            // Bus write: clamp and restart the change blink
            n_value = (i_wr_value > 8'(i_cfg.eff_max)) ? i_cfg.eff_max
                                                      : i_wr_value[6:0];
            n_chg_t = i_now;
            n_blink = 1'b1;
        end
    end

    // Hold channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value  <= '0;
            r_act_t  <= '0;
            r_chg_t  <= '0;
            r_tog_t  <= '0;
            r_hold_t <= '0;
            r_hold   <= 1'b0;
            r_lock   <= 1'b0;
            r_blink  <= 1'b0;
            r_lit    <= 1'b1;
        end else if (i_en) begin
            r_value  <= n_value;
            r_act_t  <= n_act_t;
            r_chg_t  <= n_chg_t;
            r_tog_t  <= n_tog_t;
            r_hold_t <= n_hold_t;
            r_hold   <= n_hold;
            r_lock   <= n_lock;
            r_blink  <= n_blink;
            r_lit    <= n_lit;
        end
    end

    // Present the updated view to the result register
    assign o_view.value  = n_value;
    assign o_view.lit    = n_lit;
    assign o_view.locked = n_lock;
    assign o_view.pushed = pushed;

endmodule

// ===== sv/dual_setpoint_panel_controller.sv =====
// ----------------------------------------------------------------------------
// Dual setpoint panel controller
// Two-channel setpoint panel with debounced buttons, lock and blinking.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel. tuser selects a millisecond tick
// carrying the four button levels or a bus write carrying kind, channel and
// value. Every request yields exactly one result on m_axis with both values,
// the four digit segment patterns and the lit, locked and pushed flags.
// The panel timings and the value limit sit in APB registers at byte
// addresses 0, 4, 8, 12, 16 and 20; write them only while no request is
// in flight.
// Each request is caught in an input register; the channel update then runs
// combinationally and lands in the result register, which presents it on
// m_axis. One request is taken every cycle while the receiver keeps up; the
// rate is set by the combinational channel update between those two
// registers.
// A stalled receiver holds the result; one more request may wait in the
// input register, and s_axis_tready drops only when both are full.
// Reset clears both values, locks and blink timers, lights both displays,
// restores the register defaults and empties both stages at once.
// ----------------------------------------------------------------------------
module dual_setpoint_panel_controller #(
    parameter int TIME_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] up_one, [1] down_one, [2] up_two, [3] down_two,
    // [11:4] msg_kind, [19:12] msg_channel, [27:20] msg_value, [31:28] zero
    input  logic [31:0] s_axis_tdata,
    // [0] req_type
    input  logic        s_axis_tuser,
    // Result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [6:0] level_one, [13:7] level_two, [20:14] seg_one_tens,
    // [27:21] seg_one_units, [34:28] seg_two_tens, [41:35] seg_two_units,
    // [42] lit_one, [43] lit_two, [44] locked_one, [45] locked_two,
    // [46] pushed_one, [47] pushed_two
    output logic [47:0] m_axis_tdata,
    // Register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dspc_pkg::*;

    // Register word indexes
    localparam logic [2:0] REG_DEBOUNCE   = 3'd0;
    localparam logic [2:0] REG_LOCK_HOLD  = 3'd1;
    localparam logic [2:0] REG_BLINK_LEN  = 3'd2;
    localparam logic [2:0] REG_BLINK_HALF = 3'd3;
    localparam logic [2:0] REG_LOCK_HALF  = 3'd4;
    localparam logic [2:0] REG_MAX_VALUE  = 3'd5;

    logic [15:0]          r_debounce;
    logic [15:0]          r_lock_hold;
    logic [15:0]          r_blink_len;
    logic [15:0]          r_blink_half;
    logic [15:0]          r_lock_half;
    logic [6:0]           r_max_value;
    logic                 cfg_wr;
    logic [2:0]           reg_idx;
    t_chan_cfg            chan_cfg;

    logic                 r_in_vld;
    logic [31:0]          r_in_data;
    logic                 r_in_type;
    logic                 r_out_vld;
    logic [47:0]          r_out_data;
    logic                 adv;
    logic                 tick;
    logic [7:0]           msg_kind;
    logic [7:0]           msg_chan;
    logic                 wr_one;
    logic                 wr_two;
    logic [TIME_BITS-1:0] r_now;
    logic [TIME_BITS-1:0] n_now;
    t_chan_view           view_one;
    t_chan_view           view_two;
    logic [6:0]           seg_one_tens, seg_one_units;
    logic [6:0]           seg_two_tens, seg_two_units;

    // Register port decode
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Write the timing and limit registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= 16'd50;
            r_lock_hold  <= 16'd2000;
            r_blink_len  <= 16'd1000;
            r_blink_half <= 16'd250;
            r_lock_half  <= 16'd100;
            r_max_value  <= 7'd99;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_DEBOUNCE:   r_debounce   <= pwdata[15:0];
                REG_LOCK_HOLD:  r_lock_hold  <= pwdata[15:0];
                REG_BLINK_LEN:  r_blink_len  <= pwdata[15:0];
                REG_BLINK_HALF: r_blink_half <= pwdata[15:0];
                REG_LOCK_HALF:  r_lock_half  <= pwdata[15:0];
                REG_MAX_VALUE:  r_max_value  <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    // Read back the registers
    always_comb begin
        unique case (reg_idx)
            REG_DEBOUNCE:   prdata = 32'(r_debounce);
            REG_LOCK_HOLD:  prdata = 32'(r_lock_hold);
            REG_BLINK_LEN:  prdata = 32'(r_blink_len);
            REG_BLINK_HALF: prdata = 32'(r_blink_half);
            REG_LOCK_HALF:  prdata = 32'(r_lock_half);
            REG_MAX_VALUE:  prdata = 32'(r_max_value);
            default:        prdata = 32'd0;
        endcase
    end

    // Settings for both channels, limit capped at the display range
    assign chan_cfg.debounce_ms       = r_debounce;
    assign chan_cfg.lock_hold_ms      = r_lock_hold;
    assign chan_cfg.change_blink_len  = r_blink_len;
    assign chan_cfg.change_blink_half = r_blink_half;
    assign chan_cfg.lock_blink_half   = r_lock_half;
    assign chan_cfg.eff_max = (r_max_value > VALUE_CEIL) ? VALUE_CEIL : r_max_value;

    // Stage handshakes: advance when the result register is free
    assign adv           = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || adv;

    // Catch the incoming request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata;
            r_in_type <= s_axis_tuser;
        end
    end

    // Decode the held request
    assign tick     = (r_in_type == REQ_TICK);
    assign msg_kind = r_in_data[11:4];
    assign msg_chan = r_in_data[19:12];
    assign wr_one   = (r_in_type == REQ_WRITE) && (msg_kind == MSG_KIND_VALUE)
                      && (msg_chan == MSG_CHAN_ONE);
    assign wr_two   = (r_in_type == REQ_WRITE) && (msg_kind == MSG_KIND_VALUE)
                      && (msg_chan == MSG_CHAN_TWO);

    // Advance time on each tick
    assign n_now = tick ? TIME_BITS'(r_now + TIME_BITS'(1)) : r_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now <= '0;
        end else if (adv) begin
            r_now <= n_now;
        end
    end

    dspc_chan #(.TIME_BITS(TIME_BITS)) u_chan_one (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (adv),
        .i_tick     (tick),
        .i_up       (r_in_data[0]),
        .i_dn       (r_in_data[1]),
        .i_wr       (wr_one),
        .i_wr_value (r_in_data[27:20]),
        .i_now      (n_now),
        .i_cfg      (chan_cfg),
        .o_view     (view_one)
    );

    dspc_chan #(.TIME_BITS(TIME_BITS)) u_chan_two (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (adv),
        .i_tick     (tick),
        .i_up       (r_in_data[2]),
        .i_dn       (r_in_data[3]),
        .i_wr       (wr_two),
        .i_wr_value (r_in_data[27:20]),
        .i_now      (n_now),
        .i_cfg      (chan_cfg),
        .o_view     (view_two)
    );

    dspc_seg u_seg_one (
        .i_value     (view_one.value),
        .i_lit       (view_one.lit),
        .o_seg_tens  (seg_one_tens),
        .o_seg_units (seg_one_units)
    );

    dspc_seg u_seg_two (
        .i_value     (view_two.value),
        .i_lit       (view_two.lit),
        .o_seg_tens  (seg_two_tens),
        .o_seg_units (seg_two_units)
    );

    // Result register: load on advance, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= {view_two.pushed, view_one.pushed,
                           view_two.locked, view_one.locked,
                           view_two.lit,    view_one.lit,
                           seg_two_units, seg_two_tens,
                           seg_one_units, seg_one_tens,
                           view_two.value, view_one.value};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== sv/dspc_checker.sv =====
// ----------------------------------------------------------------------------
// Dual setpoint panel checker
// Port-level checks on the result stream and register port.
// ----------------------------------------------------------------------------
module dspc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        pready
);

    // The register port never waits
    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

    // Reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // A button step never lands on a locked channel
    a_push_unlocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[46] && m_axis_tdata[44])
                          && !(m_axis_tdata[47] && m_axis_tdata[45]))
        else $error("pushed on a locked channel");

    // A dark channel shows blank digits
    a_dark_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[42] || m_axis_tdata[27:14] == 14'd0)
                          && (m_axis_tdata[43] || m_axis_tdata[41:28] == 14'd0))
        else $error("dark channel shows segments");

endmodule

bind dual_setpoint_panel_controller dspc_checker u_dspc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual setpoint panel controller testbench
// Drives ticks and bus writes into the panel, predicts every result with a
// self-contained model of both channels, and checks each result field by
// field. A short directed table covers reset, clamping, ignored writes,
// saturated presses, lock and unlock. Random phases with several register
// settings follow. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import dspc_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_ITEMS  = 245;
    localparam int SCRIPT_ROWS  = 32;

    // Segments a..g at bit6..bit0 for the decimal digits
    localparam logic [6:0] DIGIT_SEG [10] = '{
        7'h7E, 7'h30, 7'h6D, 7'h79, 7'h33, 7'h5B, 7'h5F, 7'h70, 7'h7F, 7'h7B
    };

    typedef enum int {
        REG_DEBOUNCE   = 0,
        REG_LOCK_HOLD  = 1,
        REG_BLINK_LEN  = 2,
        REG_BLINK_HALF = 3,
        REG_LOCK_HALF  = 4,
        REG_MAX_VALUE  = 5
    } t_reg_idx;

    typedef enum int {PRESS_NONE, PRESS_UP, PRESS_DOWN, PRESS_BOTH} t_press_mode;

    typedef enum int {ROW_REQ, ROW_KNOWN, ROW_CFG} t_row_kind;

    typedef struct packed {
        logic       req_type;
        logic [7:0] msg_value;
        logic [7:0] msg_channel;
        logic [7:0] msg_kind;
        logic       down_two;
        logic       up_two;
        logic       down_one;
        logic       up_one;
    } t_panel_req;

    // Field order matches m_axis_tdata, lowest field last
    typedef struct packed {
        logic       pushed_two;
        logic       pushed_one;
        logic       locked_two;
        logic       locked_one;
        logic       lit_two;
        logic       lit_one;
        logic [6:0] seg_two_units;
        logic [6:0] seg_two_tens;
        logic [6:0] seg_one_units;
        logic [6:0] seg_one_tens;
        logic [6:0] level_two;
        logic [6:0] level_one;
    } t_panel_view;

    typedef struct {
        t_row_kind   kind;
        t_panel_req  req;
        t_panel_view want;
        t_reg_idx    reg_id;
        logic [15:0] reg_val;
    } t_script_row;

    // DUT connections
    logic        i_clk;
    logic        i_rst_n        = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata   = '0;
    logic        s_axis_tuser   = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [4:0]  paddr          = '0;
    logic [31:0] pwdata         = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predicted panel state and register copies
    logic [31:0] now_ms;
    logic [6:0]  level_q   [2];
    logic [31:0] action_at [2];
    logic [31:0] change_at [2];
    logic [31:0] toggle_at [2];
    logic [31:0] hold_at   [2];
    bit          holding   [2];
    bit          locked_q  [2];
    bit          blinking  [2];
    bit          lit_q     [2];
    logic [15:0] cfg_debounce;
    logic [15:0] cfg_hold;
    logic [15:0] cfg_blink_len;
    logic [15:0] cfg_blink_half;
    logic [15:0] cfg_lock_half;
    logic [6:0]  cfg_max;

    t_panel_view pending_views [$];
    int          mismatch_count = 0;
    int          results_seen   = 0;
    int          cycle_count    = 0;
    int          stall_left     = 0;
    bit          calm           = 1'b0;

    dual_setpoint_panel_controller dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Panel predictor
    // ------------------------------------------------------------------
    function automatic logic [6:0] top_value();
        return (cfg_max > VALUE_CEIL) ? VALUE_CEIL : cfg_max;
    endfunction

    function automatic logic [31:0] elapsed(input logic [31:0] mark);
        return now_ms - mark;
    endfunction

    // Handle one channel's buttons; return whether an up or down step took effect
    function automatic bit press_buttons(input int c, input bit up, input bit dn);
        logic [6:0] v;
        if (elapsed(action_at[c]) <= {16'd0, cfg_debounce}) return 1'b0;
        if (up && dn) begin
            if (!holding[c]) begin
                holding[c] = 1'b1;
                hold_at[c] = now_ms;
            end else if (elapsed(hold_at[c]) >= {16'd0, cfg_hold}) begin
                locked_q[c] = !locked_q[c];
                // Unlocking always lights the display again
                if (!locked_q[c]) lit_q[c] = 1'b1;
                holding[c]   = 1'b0;
                action_at[c] = now_ms;
            end
            return 1'b0;
        end
        holding[c] = 1'b0;
        if (locked_q[c] || !(up || dn)) return 1'b0;
        if (up) v = level_q[c] + 7'd1;
        else    v = (level_q[c] != 7'd0) ? level_q[c] - 7'd1 : 7'd0;
        if (v > top_value()) v = top_value();
        level_q[c]   = v;
        action_at[c] = now_ms;
        change_at[c] = now_ms;
        blinking[c]  = 1'b1;
        return 1'b1;
    endfunction

    // Advance the change blink or the lock blink of one channel
    function automatic void run_blink(input int c);
        if (blinking[c]) begin
            if (elapsed(change_at[c]) >= {16'd0, cfg_blink_len}) begin
                blinking[c] = 1'b0;
                lit_q[c]    = 1'b1;
            end else if (elapsed(toggle_at[c]) >= {16'd0, cfg_blink_half}) begin
                lit_q[c]     = !lit_q[c];
                toggle_at[c] = now_ms;
            end
        end else if (locked_q[c] && elapsed(toggle_at[c]) >= {16'd0, cfg_lock_half}) begin
            lit_q[c]     = !lit_q[c];
            toggle_at[c] = now_ms;
        end
    endfunction

    function automatic t_panel_view advance_panel(input t_panel_req r);
        t_panel_view v;
        bit          push_one;
        bit          push_two;
        int          ch;
        push_one = 1'b0;
        push_two = 1'b0;
        if (r.req_type == REQ_TICK) begin
            now_ms   = now_ms + 32'd1;
            push_one = press_buttons(0, r.up_one, r.down_one);
            push_two = press_buttons(1, r.up_two, r.down_two);
            run_blink(0);
            run_blink(1);
        end else if (r.msg_kind == MSG_KIND_VALUE &&
                     (r.msg_channel == MSG_CHAN_ONE || r.msg_channel == MSG_CHAN_TWO)) begin
            ch = (r.msg_channel == MSG_CHAN_ONE) ? 0 : 1;
            if (!locked_q[ch]) begin
                level_q[ch]   = (r.msg_value > {1'b0, top_value()}) ? top_value()
                                                                    : r.msg_value[6:0];
                change_at[ch] = now_ms;
                blinking[ch]  = 1'b1;
            end
        end
        v.level_one     = level_q[0];
        v.level_two     = level_q[1];
        v.seg_one_tens  = lit_q[0] ? DIGIT_SEG[4'(level_q[0] / 7'd10)] : 7'd0;
        v.seg_one_units = lit_q[0] ? DIGIT_SEG[4'(level_q[0] % 7'd10)] : 7'd0;
        v.seg_two_tens  = lit_q[1] ? DIGIT_SEG[4'(level_q[1] / 7'd10)] : 7'd0;
        v.seg_two_units = lit_q[1] ? DIGIT_SEG[4'(level_q[1] % 7'd10)] : 7'd0;
        v.lit_one       = lit_q[0];
        v.lit_two       = lit_q[1];
        v.locked_one    = locked_q[0];
        v.locked_two    = locked_q[1];
        v.pushed_one    = push_one;
        v.pushed_two    = push_two;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Directed table helpers
    // ------------------------------------------------------------------
    function automatic t_panel_req tick_req(input int u1, input int d1,
                                            input int u2, input int d2);
        t_panel_req r;
        r          = '0;
        r.req_type = REQ_TICK;
        r.up_one   = u1[0];
        r.down_one = d1[0];
        r.up_two   = u2[0];
        r.down_two = d2[0];
        return r;
    endfunction

    function automatic t_panel_req bus_req(input logic [7:0] kind, input logic [7:0] ch,
                                           input logic [7:0] val);
        t_panel_req r;
        r             = '0;
        r.req_type    = REQ_WRITE;
        r.msg_kind    = kind;
        r.msg_channel = ch;
        r.msg_value   = val;
        return r;
    endfunction

    // Unlocked, lit, no press: only values and digits vary
    function automatic t_panel_view lit_view(input int l1, input int l2,
                                             input logic [6:0] t1, input logic [6:0] u1,
                                             input logic [6:0] t2, input logic [6:0] u2);
        t_panel_view v;
        v               = '0;
        v.level_one     = 7'(l1);
        v.level_two     = 7'(l2);
        v.seg_one_tens  = t1;
        v.seg_one_units = u1;
        v.seg_two_tens  = t2;
        v.seg_two_units = u2;
        v.lit_one       = 1'b1;
        v.lit_two       = 1'b1;
        return v;
    endfunction

    function automatic t_script_row req_row(input t_panel_req r);
        t_script_row s;
        s.kind    = ROW_REQ;
        s.req     = r;
        s.want    = '0;
        s.reg_id  = REG_DEBOUNCE;
        s.reg_val = '0;
        return s;
    endfunction

    function automatic t_script_row known_row(input t_panel_req r, input t_panel_view v);
        t_script_row s;
        s      = req_row(r);
        s.kind = ROW_KNOWN;
        s.want = v;
        return s;
    endfunction

    function automatic t_script_row cfg_row(input t_reg_idx idx, input logic [15:0] val);
        t_script_row s;
        s         = req_row('0);
        s.kind    = ROW_CFG;
        s.reg_id  = idx;
        s.reg_val = val;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Bus tasks
    // ------------------------------------------------------------------
    // Idle length: mostly short, now and then long
    function automatic int pick_pause();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    endfunction

    // Present one request, hold it until taken, then record its prediction
    task automatic issue_request(input t_panel_req r, input bit typed,
                                 input t_panel_view want);
        t_panel_view predicted;
        if (!calm && $urandom_range(0, 2) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (pick_pause()) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.req_type;
        s_axis_tdata  <= {4'd0, r.msg_value, r.msg_channel, r.msg_kind,
                          r.down_two, r.up_two, r.down_one, r.up_one};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = advance_panel(r);
        pending_views.push_back(typed ? want : predicted);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [15:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(int'(idx) * 4);
        pwdata  <= {16'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DEBOUNCE:   cfg_debounce   = val;
            REG_LOCK_HOLD:  cfg_hold       = val;
            REG_BLINK_LEN:  cfg_blink_len  = val;
            REG_BLINK_HALF: cfg_blink_half = val;
            REG_LOCK_HALF:  cfg_lock_half  = val;
            REG_MAX_VALUE:  cfg_max        = val[6:0];
            default: ;
        endcase
    endtask

    // Drop valid, wait for every outstanding result, then let the bus idle
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_views.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s at result %0d: got %0d, want %0d",
                 what, results_seen, got, want);
        mismatch_count++;
    endtask

    // Stall the result side at random, with calm stretches
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) stall_left <= pick_pause();
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_panel_view got;
        t_panel_view want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_views.size() == 0) begin
                note_mismatch("unrequested result", 0, 0);
            end else begin
                want = pending_views.pop_front();
                if (got.level_one !== want.level_one)
                    note_mismatch("level_one", int'(got.level_one), int'(want.level_one));
                if (got.level_two !== want.level_two)
                    note_mismatch("level_two", int'(got.level_two), int'(want.level_two));
                if (got.seg_one_tens !== want.seg_one_tens)
                    note_mismatch("seg_one_tens", int'(got.seg_one_tens),
                                  int'(want.seg_one_tens));
                if (got.seg_one_units !== want.seg_one_units)
                    note_mismatch("seg_one_units", int'(got.seg_one_units),
                                  int'(want.seg_one_units));
                if (got.seg_two_tens !== want.seg_two_tens)
                    note_mismatch("seg_two_tens", int'(got.seg_two_tens),
                                  int'(want.seg_two_tens));
                if (got.seg_two_units !== want.seg_two_units)
                    note_mismatch("seg_two_units", int'(got.seg_two_units),
                                  int'(want.seg_two_units));
                if (got.lit_one !== want.lit_one)
                    note_mismatch("lit_one", int'(got.lit_one), int'(want.lit_one));
                if (got.lit_two !== want.lit_two)
                    note_mismatch("lit_two", int'(got.lit_two), int'(want.lit_two));
                if (got.locked_one !== want.locked_one)
                    note_mismatch("locked_one", int'(got.locked_one), int'(want.locked_one));
                if (got.locked_two !== want.locked_two)
                    note_mismatch("locked_two", int'(got.locked_two), int'(want.locked_two));
                if (got.pushed_one !== want.pushed_one)
                    note_mismatch("pushed_one", int'(got.pushed_one), int'(want.pushed_one));
                if (got.pushed_two !== want.pushed_two)
                    note_mismatch("pushed_two", int'(got.pushed_two), int'(want.pushed_two));
            end
            results_seen++;
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        t_script_row directed_rows [SCRIPT_ROWS];
        t_panel_req  r;
        t_press_mode mode [2];
        int          run_left [2];
        logic [15:0] setting [6];

        // Predictor state after reset
        now_ms         = '0;
        cfg_debounce   = 16'd50;
        cfg_hold       = 16'd2000;
        cfg_blink_len  = 16'd1000;
        cfg_blink_half = 16'd250;
        cfg_lock_half  = 16'd100;
        cfg_max        = 7'd99;
        for (int c = 0; c < 2; c++) begin
            level_q[c]   = '0;
            action_at[c] = '0;
            change_at[c] = '0;
            toggle_at[c] = '0;
            hold_at[c]   = '0;
            holding[c]   = 1'b0;
            locked_q[c]  = 1'b0;
            blinking[c]  = 1'b0;
            lit_q[c]     = 1'b1;
            mode[c]      = PRESS_NONE;
            run_left[c]  = 0;
        end

        directed_rows = '{
            // reset state, clamping and ignored writes at default settings
            known_row(tick_req(0, 0, 0, 0), lit_view(0, 0, 7'h7E, 7'h7E, 7'h7E, 7'h7E)),
            known_row(bus_req(MSG_KIND_VALUE, MSG_CHAN_ONE, 8'd255),
                      lit_view(99, 0, 7'h7B, 7'h7B, 7'h7E, 7'h7E)),
            known_row(bus_req(8'd0, MSG_CHAN_ONE, 8'd5),
                      lit_view(99, 0, 7'h7B, 7'h7B, 7'h7E, 7'h7E)),
            known_row(bus_req(MSG_KIND_VALUE, 8'd0, 8'd5),
                      lit_view(99, 0, 7'h7B, 7'h7B, 7'h7E, 7'h7E)),
            known_row(bus_req(MSG_KIND_VALUE, 8'd3, 8'd5),
                      lit_view(99, 0, 7'h7B, 7'h7B, 7'h7E, 7'h7E)),
            known_row(bus_req(8'd255, MSG_CHAN_TWO, 8'd42),
                      lit_view(99, 0, 7'h7B, 7'h7B, 7'h7E, 7'h7E)),
            known_row(bus_req(MSG_KIND_VALUE, 8'd255, 8'd7),
                      lit_view(99, 0, 7'h7B, 7'h7B, 7'h7E, 7'h7E)),
            known_row(bus_req(MSG_KIND_VALUE, MSG_CHAN_TWO, 8'd42),
                      lit_view(99, 42, 7'h7B, 7'h7B, 7'h33, 7'h6D)),
            known_row(bus_req(MSG_KIND_VALUE, MSG_CHAN_TWO, 8'd100),
                      lit_view(99, 99, 7'h7B, 7'h7B, 7'h7B, 7'h7B)),
            // presses inside the debounce window
            req_row(tick_req(1, 1, 1, 1)),
            // fast settings, zero change-blink half period, limit above 99
            cfg_row(REG_DEBOUNCE, 16'd0),
            cfg_row(REG_LOCK_HOLD, 16'd1),
            cfg_row(REG_BLINK_LEN, 16'd3),
            cfg_row(REG_BLINK_HALF, 16'd0),
            cfg_row(REG_LOCK_HALF, 16'd1),
            cfg_row(REG_MAX_VALUE, 16'd127),
            // saturated press, then lock, ignored press and write, unlock
            req_row(tick_req(1, 0, 0, 0)),
            req_row(tick_req(0, 1, 0, 0)),
            req_row(tick_req(1, 1, 0, 0)),
            req_row(tick_req(1, 1, 0, 0)),
            req_row(tick_req(1, 0, 0, 0)),
            req_row(bus_req(MSG_KIND_VALUE, MSG_CHAN_ONE, 8'd3)),
            req_row(tick_req(0, 0, 0, 0)),
            req_row(tick_req(0, 0, 0, 0)),
            req_row(tick_req(1, 1, 0, 0)),
            req_row(tick_req(1, 1, 0, 0)),
            req_row(tick_req(0, 0, 0, 1)),
            req_row(tick_req(0, 0, 1, 0)),
            // zero limit clamps both presses and writes
            cfg_row(REG_MAX_VALUE, 16'd0),
            req_row(tick_req(0, 0, 1, 0)),
            req_row(bus_req(MSG_KIND_VALUE, MSG_CHAN_TWO, 8'd200)),
            req_row(tick_req(1, 1, 1, 1))
        };

        // Hold reset, then release it
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                settle();
                write_reg(directed_rows[i].reg_id, directed_rows[i].reg_val);
            end else begin
                issue_request(directed_rows[i].req, directed_rows[i].kind == ROW_KNOWN,
                              directed_rows[i].want);
            end
        end

        // Random phases, each under its own register setting
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: setting = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
                1: setting = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd127};
                2: setting = '{16'd2, 16'd3, 16'd8, 16'd2, 16'd3, 16'd99};
                default: begin
                    setting[REG_DEBOUNCE]   = 16'($urandom_range(0, 4));
                    setting[REG_LOCK_HOLD]  = 16'($urandom_range(0, 6));
                    setting[REG_BLINK_LEN]  = 16'($urandom_range(0, 15));
                    setting[REG_BLINK_HALF] = 16'($urandom_range(0, 4));
                    setting[REG_LOCK_HALF]  = 16'($urandom_range(0, 4));
                    case ($urandom_range(0, 5))
                        0:       setting[REG_MAX_VALUE] = 16'd0;
                        1:       setting[REG_MAX_VALUE] = 16'd1;
                        2:       setting[REG_MAX_VALUE] = 16'd99;
                        3:       setting[REG_MAX_VALUE] = 16'd127;
                        default: setting[REG_MAX_VALUE] = 16'($urandom_range(0, 127));
                    endcase
                end
            endcase
            settle();
            for (int k = 0; k < 6; k++) write_reg(t_reg_idx'(k), setting[k]);

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // Run the opening stretch of each phase without idling
                calm = (i < PHASE_ITEMS / 5);
                // Button levels held over runs so holds and locks complete
                for (int c = 0; c < 2; c++) begin
                    if (run_left[c] == 0) begin
                        mode[c]     = t_press_mode'($urandom_range(0, 3));
                        run_left[c] = $urandom_range(1, 12);
                    end
                    run_left[c]--;
                end
                r             = '0;
                r.msg_kind    = 8'($urandom);
                r.msg_channel = 8'($urandom);
                r.msg_value   = 8'($urandom);
                if ($urandom_range(0, 4) == 0) begin
                    r.req_type = REQ_WRITE;
                    {r.down_two, r.up_two, r.down_one, r.up_one} = 4'($urandom);
                    if ($urandom_range(0, 3) != 0) begin
                        r.msg_kind    = MSG_KIND_VALUE;
                        r.msg_channel = $urandom_range(0, 1) ? MSG_CHAN_ONE : MSG_CHAN_TWO;
                    end
                    if ($urandom_range(0, 1) != 0) r.msg_value = 8'($urandom_range(0, 99));
                end else begin
                    r.req_type = REQ_TICK;
                    if ($urandom_range(0, 9) == 0) begin
                        // broken sequence: unrelated button levels
                        {r.down_two, r.up_two, r.down_one, r.up_one} = 4'($urandom);
                    end else begin
                        r.up_one   = (mode[0] == PRESS_UP   || mode[0] == PRESS_BOTH);
                        r.down_one = (mode[0] == PRESS_DOWN || mode[0] == PRESS_BOTH);
                        r.up_two   = (mode[1] == PRESS_UP   || mode[1] == PRESS_BOTH);
                        r.down_two = (mode[1] == PRESS_DOWN || mode[1] == PRESS_BOTH);
                    end
                end
                issue_request(r, 1'b0, '0);
            end
        end

        // Drain and report
        calm = 1'b0;
        settle();
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/dspc_pkg.sv
sv/dspc_seg.sv
sv/dspc_chan.sv
sv/dual_setpoint_panel_controller.sv
sv/dspc_checker.sv
dv/tb_top.sv
